// ===== sv/ips_pkg.sv =====
// ----------------------------------------------------------------------------
// image placement scaler package
// Shared widths, register and mode codes, and the transaction structs.
// ----------------------------------------------------------------------------
package ips_pkg;

    localparam int QB         = 10;
    localparam int NUM_W      = 28;
    localparam int DIM_W      = 19;
    localparam int POS_W      = 21;
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = 5;
    localparam int RECIP_SH   = 19;

    localparam logic [NUM_W-1:0] RECIP_100 = 28'd5243;

    localparam logic [2:0] MODE_STRETCH = 3'd0;
    localparam logic [2:0] MODE_FILL    = 3'd1;
    localparam logic [2:0] MODE_FIT     = 3'd2;
    localparam logic [2:0] MODE_CENTER  = 3'd3;
    localparam logic [2:0] MODE_TILE    = 3'd4;

    localparam logic [2:0] REG_SCREEN_W = 3'd0;
    localparam logic [2:0] REG_SCREEN_H = 3'd1;
    localparam logic [2:0] REG_SOURCE_W = 3'd2;
    localparam logic [2:0] REG_SOURCE_H = 3'd3;
    localparam logic [2:0] REG_FIT_MODE = 3'd4;
    localparam logic [2:0] REG_BG_COLOR = 3'd5;
    localparam logic [2:0] REG_DIM      = 3'd6;

    typedef struct packed {
        logic signed [POS_W-1:0] dx0;
        logic signed [POS_W-1:0] dy0;
        logic [DIM_W-1:0]        dw;
        logic [DIM_W-1:0]        dh;
    } t_place;

    typedef struct packed {
        logic [15:0] pixel;
        logic        bg;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ===== sv/ips_place.sv =====
// ----------------------------------------------------------------------------
// ips placement sequencer
// Works out the placed rectangle from the configuration with a radix-2 divider.
// ----------------------------------------------------------------------------
module ips_place (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [10:0]    i_sw,
    input  logic [10:0]    i_sh,
    input  logic [8:0]     i_w,
    input  logic [8:0]     i_h,
    input  logic [2:0]     i_mode,
    output ips_pkg::t_place o_place,
    output logic           o_busy
);
    import ips_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_SEL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [DIM_W-1:0]   r_a, r_b, r_quo, r_dw, r_dh, w_dw_f, w_dh_f;
    logic [8:0]         r_rem, r_den;
    logic [4:0]         r_cnt;
    logic               r_to_w, r_need_div;
    logic [9:0]         w_shift, w_trial;
    logic               w_gt, w_offs;
    t_place             r_place;

    function automatic logic signed [POS_W-1:0] half_trunc(input logic signed [POS_W-1:0] v);
        logic signed [POS_W-1:0] t;
        t = v + (v[POS_W-1] ? POS_W'(1) : POS_W'(0));
        return t >>> 1;
    endfunction

    assign w_gt    = r_a > r_b;
    assign w_shift = {r_rem, r_quo[DIM_W-1]};
    assign w_trial = w_shift - {1'b0, r_den};
    assign w_dw_f  = (r_need_div && r_to_w) ? r_quo : r_dw;
    assign w_dh_f  = (r_need_div && !r_to_w) ? r_quo : r_dh;
    assign w_offs  = (i_mode == MODE_FILL) || (i_mode == MODE_FIT) || (i_mode == MODE_CENTER);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: n_state = ST_IDLE;
            ST_MUL:  n_state = ST_SEL;
            ST_SEL:  n_state = ((i_mode == MODE_FILL) || (i_mode == MODE_FIT)) ? ST_DIV : ST_FIN;
            ST_DIV:  n_state = (r_cnt == 5'd0) ? ST_FIN : ST_DIV;
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_MUL;
        end else if (i_start) begin
            r_state <= ST_MUL;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_MUL: begin
                r_a  <= DIM_W'({10'b0, i_w} * {8'b0, i_sh});
                r_b  <= DIM_W'({10'b0, i_h} * {8'b0, i_sw});
                r_dw <= DIM_W'(i_sw);
                r_dh <= DIM_W'(i_sh);
            end
            ST_SEL: begin
                r_need_div <= (i_mode == MODE_FILL) || (i_mode == MODE_FIT);
                r_to_w     <= (i_mode == MODE_FILL) ? w_gt : !w_gt;
                if ((i_mode == MODE_FILL) ? w_gt : !w_gt) begin
                    r_quo <= r_a;
                    r_den <= i_h;
                end else begin
                    r_quo <= r_b;
                    r_den <= i_w;
                end
                r_rem <= '0;
                r_cnt <= 5'(DIM_W - 1);
                if (i_mode == MODE_CENTER) begin
                    r_dw <= DIM_W'(i_w);
                    r_dh <= DIM_W'(i_h);
                end
            end
            ST_DIV: begin
                r_cnt <= r_cnt - 5'd1;
                if (!w_trial[9]) begin
                    r_rem <= w_trial[8:0];
                    r_quo <= {r_quo[DIM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[8:0];
                    r_quo <= {r_quo[DIM_W-2:0], 1'b0};
                end
            end
            ST_FIN: begin
                r_place.dw  <= w_dw_f;
                r_place.dh  <= w_dh_f;
                r_place.dx0 <= w_offs ? half_trunc($signed(POS_W'(i_sw)) - $signed(POS_W'(w_dw_f)))
                                      : '0;
                r_place.dy0 <= w_offs ? half_trunc($signed(POS_W'(i_sh)) - $signed(POS_W'(w_dh_f)))
                                      : '0;
            end
            default: ;
        endcase
    end

    assign o_place = r_place;
    assign o_busy  = r_state != ST_IDLE;

endmodule

// ===== sv/ips_divpipe.sv =====
// ----------------------------------------------------------------------------
// ips pipelined divider
// Restoring division, one quotient bit per stage, one transaction per cycle.
// ----------------------------------------------------------------------------
module ips_divpipe (
    input  logic                       i_clk,
    input  logic [ips_pkg::NUM_W-1:0]  i_num,
    input  logic [ips_pkg::DIM_W-1:0]  i_den,
    output logic [ips_pkg::QB-1:0]     o_quo,
    output logic [ips_pkg::DIM_W-1:0]  o_rem
);
    import ips_pkg::*;

    logic [NUM_W-1:0] r_rem [0:QB-1];
    logic [QB-1:0]    r_quo [0:QB-1];

    for (genvar j = 0; j < QB; j++) begin : g_stage
        logic [NUM_W-1:0] w_in;
        logic [QB-1:0]    w_qin;
        logic [NUM_W-1:0] w_sub;

        if (j == 0) begin : g_first
            assign w_in  = i_num;
            assign w_qin = '0;
        end else begin : g_next
            assign w_in  = r_rem[j-1];
            assign w_qin = r_quo[j-1];
        end

        assign w_sub = NUM_W'(i_den) << (QB - 1 - j);

        always_ff @(posedge i_clk) begin
            if (w_in >= w_sub) begin
                r_rem[j] <= w_in - w_sub;
                r_quo[j] <= w_qin | (QB'(1) << (QB - 1 - j));
            end else begin
                r_rem[j] <= w_in;
                r_quo[j] <= w_qin;
            end
        end
    end

    assign o_quo = r_quo[QB-1];
    assign o_rem = r_rem[QB-1][DIM_W-1:0];

endmodule

// ===== sv/ips_store.sv =====
// ----------------------------------------------------------------------------
// ips image store
// Source pixel memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ips_store #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [23:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);
    logic [23:0] r_mem [0:(1<<AW)-1];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ips_ofifo.sv =====
// ----------------------------------------------------------------------------
// ips output queue
// Holds finished pixels so the pipeline never stalls on the receiver.
// ----------------------------------------------------------------------------
module ips_ofifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ips_pkg::t_result       i_data,
    input  logic                   i_pop,
    output ips_pkg::t_result       o_data,
    output ips_pkg::t_fifo_stat    o_stat
);
    import ips_pkg::*;

    t_result            r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_stat.empty = r_cnt == '0;

endmodule

// ===== sv/image_placement_scaler.sv =====
// ----------------------------------------------------------------------------
// image placement scaler
// Places a stored source image on a panel and returns RGB565 screen pixels.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): cmd 0 writes one RGB888 pixel into the image
// store and gives no result; cmd 1 asks for the pixel at (screen_x, screen_y).
// Output channel (valid/ready): one pixel_565 / is_background per request,
// in request order. Configuration channel: register index and data, always
// ready; write only while no transaction is in flight.
// A request passes stages a, b, the divider, m, the store read and p1.
// Throughput: one transaction per cycle, loads and requests mixed freely.
// Loads reach the store at the same pipeline stage where requests read it,
// so a request sees every load accepted before it.
// After reset and after each configuration write, the placement unit steps
// through its multiply and select states, a divide state in fill and fit mode
// (one quotient bit a cycle) and its finish state; input ready is low then.
// Finished pixels wait in a 32-entry queue; when the receiver stalls, input
// ready drops once 32 requests are outstanding. Store contents are undefined
// after reset until loaded.
// ----------------------------------------------------------------------------
module image_placement_scaler #(
    parameter int SOURCE_PIXELS  = 65536,
    parameter int MAX_SCREEN_DIM = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [15:0] i_source_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [9:0]  i_screen_x,
    input  logic [9:0]  i_screen_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_pixel_565,
    output logic        o_is_background,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import ips_pkg::*;

    localparam int AW = $clog2(SOURCE_PIXELS);
    localparam logic [10:0] SCR_MAX = (MAX_SCREEN_DIM > 2047) ? 11'd2047 : 11'(MAX_SCREEN_DIM);

    // configuration
    logic [10:0] r_cfg_sw, r_cfg_sh;
    logic [8:0]  r_cfg_w, r_cfg_h;
    logic [2:0]  r_cfg_mode;
    logic [15:0] r_cfg_bg;
    logic [6:0]  r_cfg_dim;

    logic [10:0] w_sw, w_sh;
    logic [8:0]  w_w, w_h;
    logic [6:0]  w_light;
    logic        w_tile, w_busy, w_in_acc, w_out_acc;
    t_place      w_place;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sw   <= 11'd640;
            r_cfg_sh   <= 11'd480;
            r_cfg_w    <= 9'd256;
            r_cfg_h    <= 9'd256;
            r_cfg_mode <= MODE_FILL;
            r_cfg_bg   <= '0;
            r_cfg_dim  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCREEN_W: r_cfg_sw   <= i_cfg_data[10:0];
                REG_SCREEN_H: r_cfg_sh   <= i_cfg_data[10:0];
                REG_SOURCE_W: r_cfg_w    <= i_cfg_data[8:0];
                REG_SOURCE_H: r_cfg_h    <= i_cfg_data[8:0];
                REG_FIT_MODE: r_cfg_mode <= i_cfg_data[2:0];
                REG_BG_COLOR: r_cfg_bg   <= i_cfg_data;
                REG_DIM:      r_cfg_dim  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_sw    = (r_cfg_sw == '0) ? 11'd1 : ((r_cfg_sw > SCR_MAX) ? SCR_MAX : r_cfg_sw);
    assign w_sh    = (r_cfg_sh == '0) ? 11'd1 : ((r_cfg_sh > SCR_MAX) ? SCR_MAX : r_cfg_sh);
    assign w_w     = (r_cfg_w == '0) ? 9'd1 : ((r_cfg_w > 9'd256) ? 9'd256 : r_cfg_w);
    assign w_h     = (r_cfg_h == '0) ? 9'd1 : ((r_cfg_h > 9'd256) ? 9'd256 : r_cfg_h);
    assign w_light = 7'd100 - ((r_cfg_dim > 7'd100) ? 7'd100 : r_cfg_dim);
    assign w_tile  = r_cfg_mode == MODE_TILE;

    ips_place u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_valid),
        .i_sw    (w_sw),
        .i_sh    (w_sh),
        .i_w     (w_w),
        .i_h     (w_h),
        .i_mode  (r_cfg_mode),
        .o_place (w_place),
        .o_busy  (w_busy)
    );

    // credit for outstanding requests
    logic [FIFO_AW:0] r_credit;

    assign o_in_ready = !w_busy && (r_credit < (FIFO_AW+1)'(FIFO_DEPTH));
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_acc  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + (FIFO_AW+1)'(w_in_acc && i_cmd) - (FIFO_AW+1)'(w_out_acc);
        end
    end

    // stage a: rectangle test
    logic signed [POS_W-1:0] w_tx, w_ty;
    logic                    w_ix, w_iy;
    logic                    r_a_valid, r_a_cmd, r_a_bg;
    logic [DIM_W-1:0]        r_a_nx, r_a_ny;
    logic [15:0]             r_a_laddr;
    logic [23:0]             r_a_ldata;

    assign w_tx = $signed(POS_W'(i_screen_x)) - w_place.dx0;
    assign w_ty = $signed(POS_W'(i_screen_y)) - w_place.dy0;
    assign w_ix = !w_tx[POS_W-1] && (w_tx[POS_W-2:0] < {1'b0, w_place.dw});
    assign w_iy = !w_ty[POS_W-1] && (w_ty[POS_W-2:0] < {1'b0, w_place.dh});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_in_acc;
        end
        r_a_cmd   <= i_cmd;
        r_a_bg    <= !w_tile && !(w_ix && w_iy);
        r_a_nx    <= w_tile ? DIM_W'(i_screen_x) : w_tx[DIM_W-1:0];
        r_a_ny    <= w_tile ? DIM_W'(i_screen_y) : w_ty[DIM_W-1:0];
        r_a_laddr <= i_source_index;
        r_a_ldata <= {i_red, i_green, i_blue};
    end

    // stage b: scale numerators
    logic             r_b_valid, r_b_cmd, r_b_bg;
    logic [NUM_W-1:0] r_b_numx, r_b_numy;
    logic [15:0]      r_b_laddr;
    logic [23:0]      r_b_ldata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_cmd   <= r_a_cmd;
        r_b_bg    <= r_a_bg;
        r_b_numx  <= w_tile ? NUM_W'(r_a_nx) : ({9'b0, r_a_nx} * {19'b0, w_w});
        r_b_numy  <= w_tile ? NUM_W'(r_a_ny) : ({9'b0, r_a_ny} * {19'b0, w_h});
        r_b_laddr <= r_a_laddr;
        r_b_ldata <= r_a_ldata;
    end

    // divider stages
    logic [QB-1:0]    w_qx, w_qy;
    logic [DIM_W-1:0] w_rx, w_ry;

    ips_divpipe u_divx (
        .i_clk (i_clk),
        .i_num (r_b_numx),
        .i_den (w_tile ? DIM_W'(w_w) : w_place.dw),
        .o_quo (w_qx),
        .o_rem (w_rx)
    );

    ips_divpipe u_divy (
        .i_clk (i_clk),
        .i_num (r_b_numy),
        .i_den (w_tile ? DIM_W'(w_h) : w_place.dh),
        .o_quo (w_qy),
        .o_rem (w_ry)
    );

    logic        r_d_valid [0:QB-1];
    logic        r_d_cmd   [0:QB-1];
    logic        r_d_bg    [0:QB-1];
    logic [15:0] r_d_laddr [0:QB-1];
    logic [23:0] r_d_ldata [0:QB-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < QB; j++) begin
                r_d_valid[j] <= 1'b0;
            end
        end else begin
            r_d_valid[0] <= r_b_valid;
            for (int j = 1; j < QB; j++) begin
                r_d_valid[j] <= r_d_valid[j-1];
            end
        end
        r_d_cmd[0]   <= r_b_cmd;
        r_d_bg[0]    <= r_b_bg;
        r_d_laddr[0] <= r_b_laddr;
        r_d_ldata[0] <= r_b_ldata;
        for (int j = 1; j < QB; j++) begin
            r_d_cmd[j]   <= r_d_cmd[j-1];
            r_d_bg[j]    <= r_d_bg[j-1];
            r_d_laddr[j] <= r_d_laddr[j-1];
            r_d_ldata[j] <= r_d_ldata[j-1];
        end
    end

    // stage m: store address
    logic [8:0]    w_sx, w_sy;
    logic          r_m_valid, r_m_cmd, r_m_bg;
    logic [AW-1:0] r_m_addr;
    logic [15:0]   r_m_laddr;
    logic [23:0]   r_m_ldata;
    logic [23:0]   w_rdata;

    assign w_sx = w_tile ? w_rx[8:0]
                : ((w_qx >= {1'b0, w_w}) ? (w_w - 9'd1) : w_qx[8:0]);
    assign w_sy = w_tile ? w_ry[8:0]
                : ((w_qy >= {1'b0, w_h}) ? (w_h - 9'd1) : w_qy[8:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= r_d_valid[QB-1];
        end
        r_m_cmd   <= r_d_cmd[QB-1];
        r_m_bg    <= r_d_bg[QB-1];
        r_m_addr  <= AW'(({8'b0, w_sy} * {8'b0, w_w}) + {8'b0, w_sx});
        r_m_laddr <= r_d_laddr[QB-1];
        r_m_ldata <= r_d_ldata[QB-1];
    end

    ips_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_m_valid && !r_m_cmd),
        .i_waddr (AW'(r_m_laddr)),
        .i_wdata (r_m_ldata),
        .i_raddr (r_m_addr),
        .o_rdata (w_rdata)
    );

    // stage r, p1: dimming and packing
    logic        r_r_valid, r_r_bg, r_p1_valid, r_p1_bg;
    logic [14:0] r_p1_r, r_p1_g, r_p1_b;
    logic [NUM_W-1:0] w_sr, w_sg, w_sb;
    t_result     w_push_data, w_fifo_data;
    t_fifo_stat  w_fstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid  <= 1'b0;
            r_p1_valid <= 1'b0;
        end else begin
            r_r_valid  <= r_m_valid && r_m_cmd;
            r_p1_valid <= r_r_valid;
        end
        r_r_bg  <= r_m_bg;
        r_p1_bg <= r_r_bg;
        r_p1_r  <= {7'b0, w_rdata[23:16]} * {8'b0, w_light};
        r_p1_g  <= {7'b0, w_rdata[15:8]} * {8'b0, w_light};
        r_p1_b  <= {7'b0, w_rdata[7:0]} * {8'b0, w_light};
    end

    assign w_sr = {13'b0, r_p1_r} * RECIP_100;
    assign w_sg = {13'b0, r_p1_g} * RECIP_100;
    assign w_sb = {13'b0, r_p1_b} * RECIP_100;

    assign w_push_data.pixel = r_p1_bg ? r_cfg_bg
        : {w_sr[RECIP_SH+7:RECIP_SH+3], w_sg[RECIP_SH+7:RECIP_SH+2], w_sb[RECIP_SH+7:RECIP_SH+3]};
    assign w_push_data.bg = r_p1_bg;

    ips_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p1_valid),
        .i_data  (w_push_data),
        .i_pop   (w_out_acc),
        .o_data  (w_fifo_data),
        .o_stat  (w_fstat)
    );

    assign o_out_valid     = !w_fstat.empty;
    assign o_pixel_565     = w_fifo_data.pixel;
    assign o_is_background = w_fifo_data.bg;

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("request credit above queue depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> !w_fstat.full)
        else $error("result pushed into a full queue");

    a_result_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_credit != '0))
        else $error("result offered with no outstanding request");
`endif

endmodule
